// File: sv/mogt_pkg.sv
// shared types and constants for the min order graph traversal core
// no dependencies
package mogt_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = 7;
    localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int KIND_W    = 2;

    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RUN   = 2'd2;

    localparam logic [NODE_W-1:0] NODE_COUNT_RESET = NODE_W'(64);
    localparam logic [NODE_W-1:0] NODE_MAX         = NODE_W'(MAX_NODES);

    typedef logic [MAX_NODES-1:0] t_row;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [NODE_W-1:0]    t_node;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_WR_A,
        ST_ADD_WR_B,
        ST_PICK,
        ST_UPDATE
    } t_state;

    // result of the lowest set bit search
    typedef struct packed {
        logic any;
        t_idx idx;
    } t_pick;

    // bit i set when node i+1 is within the effective node count
    function automatic t_row f_valid_mask(input t_node n);
        t_row m;
        m = '0;
        for (int i = 0; i < MAX_NODES; i++) begin
            m[i] = (NODE_W'(i) < n);
        end
        return m;
    endfunction

endpackage

// File: sv/mogt_ram.sv
// generic single write port ram with registered read
// no dependencies
module mogt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/mogt_pick.sv
// lowest set bit search over the pending node mask
// depends on mogt_pkg
module mogt_pick (
    input  mogt_pkg::t_row  i_mask,
    output mogt_pkg::t_pick o_pick
);

    mogt_pkg::t_row iso;
    mogt_pkg::t_idx idx;

    // isolate the lowest set bit, then encode the one-hot word
    assign iso = i_mask & (~i_mask + mogt_pkg::t_row'(1));

    always_comb begin
        idx = '0;
        for (int i = 0; i < mogt_pkg::MAX_NODES; i++) begin
            if (iso[i]) begin
                idx = idx | mogt_pkg::IDX_W'(i);
            end
        end
    end

    assign o_pick.any = |i_mask;
    assign o_pick.idx = idx;

endmodule

// File: sv/min_order_graph_traversal_core.sv
// min order graph traversal core: adjacency rows in a ram, pending bitmap walk
// clear acts as soon as it is accepted; add edge goes through ST_ADD_WR_A then ST_ADD_WR_B
// (read-modify-write of both rows); run goes through ST_PICK then ST_UPDATE per emitted node
// (pick + row read), waiting in ST_UPDATE while the output is held; only one item at a time
// reset: row valid bits, discovered and pending masks and control clear at once, node_count goes to 64
// depends on mogt_pkg, mogt_pick, mogt_ram
module min_order_graph_traversal_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mogt_pkg::NODE_W-1:0]   i_cfg_node_count,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mogt_pkg::KIND_W-1:0]   i_kind,
    input  logic [mogt_pkg::NODE_W-1:0]   i_node_a,
    input  logic [mogt_pkg::NODE_W-1:0]   i_node_b,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mogt_pkg::NODE_W-1:0]   o_visit_node,
    output logic                          o_last_of_run
);

    mogt_pkg::t_state r_state, n_state;
    mogt_pkg::t_node  r_node_count;
    mogt_pkg::t_row   r_row_valid, n_row_valid;
    mogt_pkg::t_row   r_disc, n_disc;
    mogt_pkg::t_row   r_pend, n_pend;
    mogt_pkg::t_row   r_valid_mask, n_valid_mask;
    mogt_pkg::t_idx   r_idx_a, r_idx_b, r_node;
    logic             r_rd_ok;
    logic             r_out_valid;
    mogt_pkg::t_node  r_visit;
    logic             r_last;

    mogt_pkg::t_node  n_eff;
    mogt_pkg::t_idx   in_idx_a, in_idx_b;
    logic             edge_ok;
    logic             in_fire;
    logic             out_free;
    mogt_pkg::t_pick  pick;
    mogt_pkg::t_row   ram_rdata, row, fresh, upd_pend;

    logic             ram_we;
    mogt_pkg::t_idx   ram_waddr, ram_raddr;
    mogt_pkg::t_row   ram_wdata;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == mogt_pkg::ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    assign n_eff = (r_node_count > mogt_pkg::NODE_MAX) ? mogt_pkg::NODE_MAX : r_node_count;
    assign in_idx_a = mogt_pkg::IDX_W'(i_node_a - mogt_pkg::NODE_W'(1));
    assign in_idx_b = mogt_pkg::IDX_W'(i_node_b - mogt_pkg::NODE_W'(1));
    assign edge_ok  = (i_node_a != '0) && (i_node_b != '0) && (i_node_a <= n_eff)
                   && (i_node_b <= n_eff) && (i_node_a != i_node_b);

    mogt_pick u_pick (
        .i_mask (r_pend),
        .o_pick (pick)
    );

    mogt_ram #(
        .WIDTH (mogt_pkg::MAX_NODES),
        .DEPTH (mogt_pkg::MAX_NODES)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // a row never written since the last clear reads as empty
    assign row      = r_rd_ok ? ram_rdata : '0;
    assign fresh    = row & r_valid_mask & ~r_disc;
    assign upd_pend = r_pend | fresh;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mogt_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (i_kind == mogt_pkg::KIND_ADD && edge_ok) begin
                        n_state = mogt_pkg::ST_ADD_WR_A;
                    end else if (i_kind == mogt_pkg::KIND_RUN && n_eff != '0) begin
                        n_state = mogt_pkg::ST_PICK;
                    end
                end
            end
            mogt_pkg::ST_ADD_WR_A: n_state = mogt_pkg::ST_ADD_WR_B;
            mogt_pkg::ST_ADD_WR_B: n_state = mogt_pkg::ST_IDLE;
            mogt_pkg::ST_PICK:     n_state = mogt_pkg::ST_UPDATE;
            mogt_pkg::ST_UPDATE: begin
                if (out_free) begin
                    n_state = (upd_pend == '0) ? mogt_pkg::ST_IDLE : mogt_pkg::ST_PICK;
                end
            end
            default: n_state = mogt_pkg::ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        ram_we       = 1'b0;
        ram_waddr    = r_idx_a;
        ram_wdata    = row | (mogt_pkg::t_row'(1) << r_idx_b);
        ram_raddr    = r_idx_a;
        n_row_valid  = r_row_valid;
        n_disc       = r_disc;
        n_pend       = r_pend;
        n_valid_mask = r_valid_mask;
        case (r_state)
            mogt_pkg::ST_IDLE: begin
                ram_raddr = in_idx_a;
                if (in_fire) begin
                    case (i_kind)
                        mogt_pkg::KIND_CLEAR: begin
                            n_row_valid = '0;
                            n_disc      = '0;
                            n_pend      = '0;
                        end
                        mogt_pkg::KIND_RUN: begin
                            n_valid_mask = mogt_pkg::f_valid_mask(n_eff);
                            n_disc       = (n_eff != '0) ? mogt_pkg::t_row'(1) : '0;
                            n_pend       = (n_eff != '0) ? mogt_pkg::t_row'(1) : '0;
                        end
                        default: ;
                    endcase
                end
            end
            mogt_pkg::ST_ADD_WR_A: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx_a;
                ram_wdata = row | (mogt_pkg::t_row'(1) << r_idx_b);
                ram_raddr = r_idx_b;
                n_row_valid[r_idx_a] = 1'b1;
            end
            mogt_pkg::ST_ADD_WR_B: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx_b;
                ram_wdata = row | (mogt_pkg::t_row'(1) << r_idx_a);
                ram_raddr = r_idx_b;
                n_row_valid[r_idx_b] = 1'b1;
            end
            mogt_pkg::ST_PICK: begin
                ram_raddr = pick.idx;
                n_pend[pick.idx] = 1'b0;
            end
            mogt_pkg::ST_UPDATE: begin
                ram_raddr = r_node;
                if (out_free) begin
                    n_disc = r_disc | fresh;
                    n_pend = upd_pend;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mogt_pkg::ST_IDLE;
            r_node_count <= mogt_pkg::NODE_COUNT_RESET;
            r_row_valid  <= '0;
            r_disc       <= '0;
            r_pend       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_valid <= n_row_valid;
            r_disc      <= n_disc;
            r_pend      <= n_pend;
            if (i_cfg_valid) begin
                r_node_count <= i_cfg_node_count;
            end
            if (r_state == mogt_pkg::ST_UPDATE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_valid_mask <= n_valid_mask;
        r_rd_ok      <= r_row_valid[ram_raddr];
        if (r_state == mogt_pkg::ST_IDLE) begin
            r_idx_a <= in_idx_a;
            r_idx_b <= in_idx_b;
        end
        if (r_state == mogt_pkg::ST_PICK) begin
            r_node <= pick.idx;
        end
        if (r_state == mogt_pkg::ST_UPDATE && out_free) begin
            r_visit <= mogt_pkg::NODE_W'(r_node) + mogt_pkg::NODE_W'(1);
            r_last  <= (upd_pend == '0);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_visit_node  = r_visit;
    assign o_last_of_run = r_last;

endmodule

// File: tb/tb_top.sv
// self-checking testbench for min_order_graph_traversal_core: edge, clear, run and unused-kind beats
// go in, each visit beat out is checked against a bitmap walk kept in this file
// depends on mogt_pkg and the core rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [mogt_pkg::KIND_W-1:0] t_kind;

    localparam t_kind KIND_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS  = 125;
    localparam int STUCK_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 2 * mogt_pkg::MAX_NODES + 8;
    localparam int LONG_HOLD     = 300;

    typedef struct packed {
        mogt_pkg::t_node node;
        logic            last;
    } t_visit;

    logic                        i_clk            = 1'b0;
    logic                        i_rst_n          = 1'b0;
    logic                        i_cfg_valid      = 1'b0;
    logic                        o_cfg_ready;
    logic [mogt_pkg::NODE_W-1:0] i_cfg_node_count = '0;
    logic                        i_in_valid       = 1'b0;
    logic                        o_in_ready;
    t_kind                       i_kind           = '0;
    logic [mogt_pkg::NODE_W-1:0] i_node_a         = '0;
    logic [mogt_pkg::NODE_W-1:0] i_node_b         = '0;
    logic                        o_out_valid;
    logic                        i_out_ready      = 1'b0;
    logic [mogt_pkg::NODE_W-1:0] o_visit_node;
    logic                        o_last_of_run;

    // graph as the core should hold it
    mogt_pkg::t_row  adj_rows [mogt_pkg::MAX_NODES] = '{default: '0};
    mogt_pkg::t_row  seen_set   = '0;
    mogt_pkg::t_row  open_set   = '0;
    mogt_pkg::t_node cur_node_count = mogt_pkg::NODE_COUNT_RESET;
    t_visit          visit_q [$];

    int errors         = 0;
    int items_sent     = 0;
    int runs_sent      = 0;
    int visits_checked = 0;
    int stuck_cycles   = 0;
    int hold_req       = 0;
    int hold_left      = 0;
    int rx_gap         = 0;
    bit tx_calm        = 1'b0;
    bit rx_calm        = 1'b0;

    min_order_graph_traversal_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_node_count (i_cfg_node_count),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_node_a         (i_node_a),
        .i_node_b         (i_node_b),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_visit_node     (o_visit_node),
        .o_last_of_run    (o_last_of_run)
    );

    initial forever #1 i_clk = ~i_clk;

    // mostly back to back, often a short gap, now and then a long one
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic mogt_pkg::t_node rand_endpoint(input int lim);
        if (lim == 0) return mogt_pkg::t_node'($urandom_range(0, 127));
        return mogt_pkg::t_node'($urandom_range(1, lim));
    endfunction

    // applies one accepted beat to the graph and queues the visits it produces
    function automatic void walk_graph(input t_kind kind, input mogt_pkg::t_node a,
                                       input mogt_pkg::t_node b);
        mogt_pkg::t_row in_range;
        mogt_pkg::t_row fresh;
        t_visit         v;
        int             lim;
        int             pos;
        int             steps;
        lim      = (cur_node_count > mogt_pkg::NODE_MAX) ? mogt_pkg::MAX_NODES
                                                         : int'(cur_node_count);
        in_range = (lim >= mogt_pkg::MAX_NODES) ? '1
                 : ((mogt_pkg::t_row'(1) << lim) - mogt_pkg::t_row'(1));
        case (kind)
            mogt_pkg::KIND_CLEAR: begin
                foreach (adj_rows[i]) adj_rows[i] = '0;
                seen_set = '0;
                open_set = '0;
            end
            mogt_pkg::KIND_ADD: begin
                if (int'(a) >= 1 && int'(b) >= 1 && int'(a) <= lim && int'(b) <= lim
                    && a != b) begin
                    adj_rows[int'(a) - 1][int'(b) - 1] = 1'b1;
                    adj_rows[int'(b) - 1][int'(a) - 1] = 1'b1;
                end
            end
            mogt_pkg::KIND_RUN: begin
                seen_set = '0;
                open_set = '0;
                if (lim > 0) begin
                    seen_set = mogt_pkg::t_row'(1);
                    open_set = mogt_pkg::t_row'(1);
                    steps    = 0;
                    while (open_set != '0 && steps < mogt_pkg::MAX_NODES) begin
                        pos = mogt_pkg::MAX_NODES - 1;
                        for (int i = mogt_pkg::MAX_NODES - 1; i >= 0; i--) begin
                            if (open_set[i]) pos = i;
                        end
                        open_set[pos] = 1'b0;
                        // neighbours beyond the node count stay hidden
                        fresh     = adj_rows[pos] & in_range & ~seen_set;
                        seen_set |= fresh;
                        open_set |= fresh;
                        v.node = mogt_pkg::t_node'(pos + 1);
                        v.last = (open_set == '0);
                        visit_q = {visit_q, v};
                        steps++;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(input t_kind kind, input mogt_pkg::t_node a,
                             input mogt_pkg::t_node b);
        int gap;
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_node_a   <= a;
        i_node_b   <= b;
        do @(posedge i_clk); while (!o_in_ready);
        walk_graph(kind, a, b);
        items_sent++;
        if (kind == mogt_pkg::KIND_RUN) runs_sent++;
        gap = tx_calm ? 0 : idle_len();
        // valid stays up only when the next beat follows in this same step
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (visit_q.size() != 0) @(posedge i_clk);
        // an add beat has no visit to wait on
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_node_count(input mogt_pkg::t_node value);
        i_cfg_valid      <= 1'b1;
        i_cfg_node_count <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_node_count = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_empty_graph_walk();
        send_item(mogt_pkg::KIND_RUN, 0, 0);
        send_item(KIND_UNUSED, 127, 127);
        send_item(mogt_pkg::KIND_RUN, 127, 127);
    endtask

    task automatic check_edge_rules();
        send_item(mogt_pkg::KIND_ADD, 1, 64);
        send_item(mogt_pkg::KIND_ADD, 64, 1);
        send_item(mogt_pkg::KIND_ADD, 5, 5);
        send_item(mogt_pkg::KIND_ADD, 0, 3);
        send_item(mogt_pkg::KIND_ADD, 65, 2);
        send_item(mogt_pkg::KIND_ADD, 127, 127);
        send_item(mogt_pkg::KIND_ADD, 1, 3);
        send_item(mogt_pkg::KIND_ADD, 3, 2);
        send_item(mogt_pkg::KIND_ADD, 64, 63);
        send_item(mogt_pkg::KIND_RUN, 0, 0);
        send_item(mogt_pkg::KIND_CLEAR, 127, 0);
        send_item(mogt_pkg::KIND_RUN, 0, 0);
    endtask

    task automatic check_node_count_limits();
        send_item(mogt_pkg::KIND_ADD, 2, 64);
        send_item(mogt_pkg::KIND_ADD, 1, 2);
        wait_drained();
        write_node_count(1);
        send_item(mogt_pkg::KIND_RUN, 0, 0);
        send_item(mogt_pkg::KIND_ADD, 1, 2);
        wait_drained();
        write_node_count(0);
        send_item(mogt_pkg::KIND_ADD, 1, 2);
        send_item(mogt_pkg::KIND_RUN, 0, 0);
        wait_drained();
        write_node_count(127);
        send_item(mogt_pkg::KIND_RUN, 0, 0);
        wait_drained();
        // node 64 is still stored but out of reach now
        write_node_count(3);
        send_item(mogt_pkg::KIND_RUN, 0, 0);
    endtask

    task automatic check_random_graphs();
        int target;
        int roll;
        int n;
        int lim;
        int edges;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            wait_drained();
            roll = $urandom_range(0, 99);
            if (roll < 40)      n = $urandom_range(2, 8);
            else if (roll < 70) n = $urandom_range(9, 24);
            else if (roll < 80) n = mogt_pkg::MAX_NODES;
            else if (roll < 85) n = 1;
            else if (roll < 90) n = 0;
            else if (roll < 95) n = $urandom_range(65, 127);
            else                n = $urandom_range(25, 63);
            write_node_count(mogt_pkg::t_node'(n));
            lim     = (n > mogt_pkg::MAX_NODES) ? mogt_pkg::MAX_NODES : n;
            tx_calm = ($urandom_range(0, 4) == 0);
            rx_calm = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 3)) begin
                if (items_sent >= target) break;
                if ($urandom_range(0, 4) != 0) begin
                    send_item(mogt_pkg::KIND_CLEAR, mogt_pkg::t_node'($urandom_range(0, 127)),
                              mogt_pkg::t_node'($urandom_range(0, 127)));
                end
                edges = (lim == mogt_pkg::MAX_NODES) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 2 * lim + 2);
                repeat (edges) begin
                    if (items_sent >= target) break;
                    if ($urandom_range(0, 9) == 0) begin
                        send_item(t_kind'($urandom_range(0, 3)),
                                  mogt_pkg::t_node'($urandom_range(0, 127)),
                                  mogt_pkg::t_node'($urandom_range(0, 127)));
                    end else begin
                        send_item(mogt_pkg::KIND_ADD, rand_endpoint(lim), rand_endpoint(lim));
                    end
                end
                repeat ($urandom_range(1, 2)) begin
                    send_item(mogt_pkg::KIND_RUN, mogt_pkg::t_node'($urandom_range(0, 127)),
                              mogt_pkg::t_node'($urandom_range(0, 127)));
                end
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    task automatic check_output_backpressure();
        wait_drained();
        write_node_count(16);
        tx_calm = 1'b1;
        send_item(mogt_pkg::KIND_CLEAR, 0, 0);
        for (int i = 1; i < 16; i++) begin
            send_item(mogt_pkg::KIND_ADD, mogt_pkg::t_node'(i), mogt_pkg::t_node'(i + 1));
        end
        // receiver goes quiet while runs keep coming, so the core backs up
        hold_req = LONG_HOLD;
        send_item(mogt_pkg::KIND_RUN, 0, 0);
        send_item(mogt_pkg::KIND_ADD, 16, 1);
        send_item(mogt_pkg::KIND_RUN, 0, 0);
        send_item(mogt_pkg::KIND_RUN, 0, 0);
        tx_calm = 1'b0;
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_empty_graph_walk();
        check_edge_rules();
        check_node_count_limits();
        check_random_graphs();
        check_output_backpressure();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d beats sent, %0d traversal runs, %0d visits checked",
                 items_sent, runs_sent, visits_checked);
        $display("node counts 0 to 127 and a %0d cycle output hold-off were covered", LONG_HOLD);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // output side stalls, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_gap == 0 && !rx_calm) rx_gap = idle_len();
            i_out_ready <= (rx_gap == 0);
            if (rx_gap > 0) rx_gap--;
        end
    end

    always @(posedge i_clk) begin : check_visit
        t_visit want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (visit_q.size() == 0) begin
                $error("unexpected visit beat: visit_node %0d last_of_run %0b",
                       o_visit_node, o_last_of_run);
                errors++;
            end else begin
                want = visit_q.pop_front();
                visits_checked++;
                if (o_visit_node !== want.node) begin
                    $error("visit_node expected %0d actual %0d", want.node, o_visit_node);
                    errors++;
                end
                if (o_last_of_run !== want.last) begin
                    $error("last_of_run expected %0b actual %0b", want.last, o_last_of_run);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

endmodule

// File: sim.f
sv/mogt_pkg.sv
sv/mogt_ram.sv
sv/mogt_pick.sv
sv/min_order_graph_traversal_core.sv
tb/tb_top.sv
